/* rtl/ial_pkg.sv */
// Shared types and codes for the identifier allowlist table.
// No dependencies; used by ial_ctrl, ial_dp and id_allowlist_table.
`default_nettype none

package ial_pkg;

    // Operation codes carried in request.func
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_DEL   = 3'd1;
    localparam logic [2:0] OP_CHECK = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    // Status codes of a result
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_REFUSED = 1'b1;

    // One request
    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] uid;
    } req_t;

    // One result
    typedef struct packed {
        logic        status;
        logic        entry_valid;
        logic [5:0]  entry_index;
        logic [31:0] entry_value;
        logic [6:0]  count;
        logic        last;
    } rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture the request
        logic idx_clr;     // scan pointer to zero
        logic idx_inc;     // advance scan pointer
        logic rd_idx;      // read store at pointer
        logic rd_nxt;      // read store at pointer + 1
        logic wr_uid;      // append request uid at the tail
        logic wr_shift;    // write last read word at pointer
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic emit;        // present a result next cycle
        logic emit_status;
        logic emit_entry;  // result carries the entry at the pointer
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [2:0] func;
        logic       uid_zero;
        logic       cnt_zero;
        logic       full;
        logic       match;     // last read word equals request uid
        logic       idx_last;  // pointer is at the final entry
        logic       idx_penult; // pointer is one before the final entry
    } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/ial_dp.sv */
// Datapath of the allowlist table: entry store, count, scan pointer, result register.
// Depends on ial_pkg for request, result, command and status types.
`default_nettype none

module ial_dp #(
    parameter int ENTRIES = 5
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ial_pkg::req_t     request,
    input  wire ial_pkg::ctl_cmd_t cmd,
    output ial_pkg::dp_stat_t      stat,
    output ial_pkg::rsp_t          result,
    output logic                   strobe
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [31:0]    mem [ENTRIES];
    ial_pkg::req_t  req_reg;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [31:0]    rd_data_reg;
    ial_pkg::rsp_t  result_reg, result_next;
    logic           strobe_reg;

    logic [IW-1:0]  rd_addr;
    logic [IW-1:0]  wr_addr;
    logic [31:0]    wr_data;
    logic [CW:0]    idx_w;
    logic           idx_last;

    // Pointer and count arithmetic
    assign idx_w    = (CW + 1)'(idx_reg);
    assign idx_last = (idx_w + (CW + 1)'(1)) == (CW + 1)'(cnt_reg);

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + IW'(1);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
            cnt_next = '0;
        else if (cmd.cnt_inc)
            cnt_next = cnt_reg + CW'(1);
        else if (cmd.cnt_dec)
            cnt_next = cnt_reg - CW'(1);
    end

    // Store addressing
    assign rd_addr = cmd.rd_nxt ? (idx_reg + IW'(1)) : idx_reg;
    assign wr_addr = cmd.wr_uid ? IW'(cnt_reg) : idx_reg;
    assign wr_data = cmd.wr_uid ? req_reg.uid : rd_data_reg;

    // Entry store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_uid || cmd.wr_shift)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_idx || cmd.rd_nxt)
            rd_data_reg <= mem[rd_addr];
        if (cmd.load)
            req_reg <= request;
    end

    // Result formatting
    always_comb
    begin
        result_next             = result_reg;
        if (cmd.emit)
        begin
            result_next.status      = cmd.emit_status;
            result_next.entry_valid = cmd.emit_entry;
            result_next.entry_index = cmd.emit_entry ? 6'(idx_reg) : 6'd0;
            result_next.entry_value = cmd.emit_entry ? rd_data_reg : 32'd0;
            result_next.count       = 7'(cnt_next);
            result_next.last        = cmd.emit_entry ? idx_last : 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= cmd.emit;
        end
    end

    // Status to the controller
    assign stat.func       = req_reg.func;
    assign stat.uid_zero   = (req_reg.uid == 32'd0);
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.full       = (cnt_reg == CW'(ENTRIES));
    assign stat.match      = (rd_data_reg == req_reg.uid);
    assign stat.idx_last   = idx_last;
    assign stat.idx_penult = (idx_w + (CW + 1)'(2)) == (CW + 1)'(cnt_reg);

    assign result = result_reg;
    assign strobe = strobe_reg;

    // Checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(ENTRIES))
        else $error("entry count above capacity");

    a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && result_reg.entry_valid |->
            result_reg.status == ial_pkg::ST_OK
            && (7'(result_reg.entry_index) < result_reg.count))
        else $error("reported entry outside the list");

    a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.emit_entry |-> !stat.cnt_zero)
        else $error("entry reported from an empty list");

    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.cnt_inc, cmd.cnt_dec, cmd.cnt_clr}) <= 1
        && !(cmd.wr_uid && cmd.wr_shift))
        else $error("conflicting store updates");

endmodule

`default_nettype wire

/* rtl/ial_ctrl.sv */
// Controller of the allowlist table: sequences scan, shift and query steps.
// Depends on ial_pkg for command, status and operation codes.
`default_nettype none

module ial_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire ial_pkg::dp_stat_t stat,
    output ial_pkg::ctl_cmd_t      cmd,
    output logic                   busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_QRY_RD,
        S_QRY_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start && !busy_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_IDLE;
                case (stat.func)
                    ial_pkg::OP_ADD:
                    begin
                        if (stat.full || stat.uid_zero)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ial_pkg::ST_REFUSED;
                        end
                        else if (stat.cnt_zero)
                        begin
                            cmd.wr_uid      = 1'b1;
                            cmd.cnt_inc     = 1'b1;
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ial_pkg::ST_OK;
                        end
                        else
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_SCAN_RD;
                        end
                    end
                    ial_pkg::OP_DEL,
                    ial_pkg::OP_CHECK:
                    begin
                        if (stat.cnt_zero || stat.uid_zero)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ial_pkg::ST_REFUSED;
                        end
                        else
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_SCAN_RD;
                        end
                    end
                    ial_pkg::OP_CLEAR:
                    begin
                        cmd.emit = 1'b1;
                        if (stat.cnt_zero)
                            cmd.emit_status = ial_pkg::ST_REFUSED;
                        else
                        begin
                            cmd.cnt_clr     = 1'b1;
                            cmd.emit_status = ial_pkg::ST_OK;
                        end
                    end
                    ial_pkg::OP_QUERY:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ial_pkg::ST_OK;
                        end
                        else
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_QRY_RD;
                        end
                    end
                    default:
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ial_pkg::ST_REFUSED;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                state_next = S_IDLE;
                if (stat.match)
                begin
                    case (stat.func)
                        ial_pkg::OP_DEL:
                        begin
                            if (stat.idx_last)
                            begin
                                cmd.cnt_dec     = 1'b1;
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ial_pkg::ST_OK;
                            end
                            else
                                state_next = S_SHIFT_RD;
                        end
                        ial_pkg::OP_CHECK:
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ial_pkg::ST_OK;
                        end
                        default:
                        begin
                            // duplicate add
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ial_pkg::ST_REFUSED;
                        end
                    endcase
                end
                else if (stat.idx_last)
                begin
                    cmd.emit = 1'b1;
                    if (stat.func == ial_pkg::OP_ADD)
                    begin
                        cmd.wr_uid      = 1'b1;
                        cmd.cnt_inc     = 1'b1;
                        cmd.emit_status = ial_pkg::ST_OK;
                    end
                    else
                        cmd.emit_status = ial_pkg::ST_REFUSED;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.rd_nxt = 1'b1;
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                // move the next entry down one place
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                if (stat.idx_penult)
                begin
                    cmd.cnt_dec     = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ial_pkg::ST_OK;
                    state_next      = S_IDLE;
                end
                else
                    state_next = S_SHIFT_RD;
            end
            S_QRY_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_QRY_OUT;
            end
            S_QRY_OUT:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_entry  = 1'b1;
                cmd.emit_status = ial_pkg::ST_OK;
                if (stat.idx_last)
                    state_next = S_IDLE;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_QRY_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy_next = (state_next != S_IDLE);

    // State and registered busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

/* rtl/id_allowlist_table.sv */
// Top level of the identifier allowlist table.
// Depends on ial_pkg, ial_ctrl and ial_dp.
//
// Usage:
//   A request (func, uid) is taken on a rising edge with start high and busy
//   low. busy then stays high until the last result of that request is
//   presented. Each result is on the result port for one cycle with strobe
//   high; the receiver cannot stall, so it must take every strobed result.
//   Operations: add, delete, check, clear, query (one result per entry or one
//   if empty; last marks the final one). Unknown codes return a single refusal.
//
// Sequence (N = entries stored, p = matching position):
//   clear, query of an empty list, refusals decided up front: the request is
//   captured, decided in the dispatch state and the result registered; busy is
//   already low while the result is presented, so the next request can be
//   taken at the same edge as the result. add / check / delete search: one store
//   read plus one compare per entry visited; a delete then moves each of the
//   N-1-p entries behind the match down one place with a read and a write
//   step. Query: each entry is read and then presented, in order.
// Reset: asynchronous, active low; empties the list and clears strobe.
// Store contents are not cleared and are only read below the count.
`default_nettype none

module id_allowlist_table #(
    parameter int ENTRIES = 5
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire ial_pkg::req_t request,
    output ial_pkg::rsp_t      result,
    output logic               strobe
);

    ial_pkg::ctl_cmd_t cmd;
    ial_pkg::dp_stat_t stat;

    // Sequencer
    ial_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Store and result path
    ial_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result),
        .strobe  (strobe)
    );

endmodule

`default_nettype wire

/* bench/id_allowlist_table_tb.sv */
// Self-checking testbench for the identifier allowlist table (id_allowlist_table).
// Depends on ial_pkg and the RTL. A built-in list predictor computes the expected
// results, and a monitor compares each strobed result against them in order.
`default_nettype none

module id_allowlist_table_tb;

    localparam int ENTRIES        = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;
    localparam int POOL_SIZE      = 8;

    // func codes the block does not define; it answers each one with a refusal
    localparam logic [2:0]  OP_FIRST_UNKNOWN = 3'd5;
    localparam logic [2:0]  OP_LAST_UNKNOWN  = 3'd7;
    localparam logic [31:0] NO_CARD          = 32'h0000_0000;
    localparam logic [31:0] ALL_ONES_CARD    = 32'hFFFF_FFFF;
    localparam logic [31:0] TOP_BIT_CARD     = 32'h8000_0000;

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    logic start   = 1'b0;
    ial_pkg::req_t request = '0;
    logic busy;
    ial_pkg::rsp_t result;
    logic strobe;

    // Predictor state: a copy of the list and the results still due
    logic [31:0]   card_list [ENTRIES];
    int            card_count = 0;
    ial_pkg::rsp_t pending_rsps [$];
    int            error_count = 0;
    int            sender_idle_pct = 0;
    int            quiet_cycles = 0;
    logic [31:0]   uid_pool [POOL_SIZE];

    always #1 clk = ~clk;

    id_allowlist_table #(
        .ENTRIES(ENTRIES)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .result (result),
        .strobe (strobe)
    );

    // Position of a nonzero card in the list, -1 if absent
    function automatic int find_card(logic [31:0] uid);
        if (uid == NO_CARD)
            return -1;
        for (int i = 0; i < card_count; i++)
        begin
            if (card_list[i] == uid)
                return i;
        end
        return -1;
    endfunction

    function automatic ial_pkg::rsp_t make_rsp(logic status, logic valid, logic [5:0] idx,
                                               logic [31:0] value, logic last);
        ial_pkg::rsp_t r;
        r.status      = status;
        r.entry_valid = valid;
        r.entry_index = idx;
        r.entry_value = value;
        r.count       = 7'(card_count);
        r.last        = last;
        return r;
    endfunction

    // Apply one request to the list copy and queue the results it causes
    function automatic void predict_list_op(ial_pkg::req_t req);
        logic status;
        int   pos;
        status = ial_pkg::ST_REFUSED;
        case (req.func)
            ial_pkg::OP_ADD:
            begin
                if (card_count < ENTRIES && req.uid != NO_CARD && find_card(req.uid) < 0)
                begin
                    card_list[card_count] = req.uid;
                    card_count++;
                    status = ial_pkg::ST_OK;
                end
            end
            ial_pkg::OP_DEL:
            begin
                pos = find_card(req.uid);
                if (pos >= 0)
                begin
                    // close the gap
                    for (int i = pos; i < card_count - 1; i++)
                        card_list[i] = card_list[i + 1];
                    card_count--;
                    status = ial_pkg::ST_OK;
                end
            end
            ial_pkg::OP_CHECK:
                status = (find_card(req.uid) >= 0) ? ial_pkg::ST_OK : ial_pkg::ST_REFUSED;
            ial_pkg::OP_CLEAR:
            begin
                if (card_count != 0)
                begin
                    card_count = 0;
                    status = ial_pkg::ST_OK;
                end
            end
            ial_pkg::OP_QUERY:
            begin
                if (card_count == 0)
                    pending_rsps.push_back(make_rsp(ial_pkg::ST_OK, 1'b0, '0, NO_CARD, 1'b1));
                for (int i = 0; i < card_count; i++)
                    pending_rsps.push_back(make_rsp(ial_pkg::ST_OK, 1'b1, 6'(i), card_list[i],
                                                    i == card_count - 1));
                return;
            end
            default:
                status = ial_pkg::ST_REFUSED;
        endcase
        pending_rsps.push_back(make_rsp(status, 1'b0, '0, NO_CARD, 1'b1));
    endfunction

    function automatic void compare_field(string name, logic [31:0] exp_val,
                                          logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            error_count++;
        end
    endfunction

    // Result monitor: every strobed result against the oldest expectation
    always @(posedge clk)
    begin
        ial_pkg::rsp_t want;
        if (rst_n && strobe)
        begin
            if (pending_rsps.size() == 0)
            begin
                $error("result with none expected: 0x%0h", result);
                error_count++;
            end
            else
            begin
                want = pending_rsps.pop_front();
                compare_field("status", 32'(want.status), 32'(result.status));
                compare_field("entry_valid", 32'(want.entry_valid),
                              32'(result.entry_valid));
                compare_field("entry_index", 32'(want.entry_index),
                              32'(result.entry_index));
                compare_field("entry_value", want.entry_value, result.entry_value);
                compare_field("count", 32'(want.count), 32'(result.count));
                compare_field("last", 32'(want.last), 32'(result.last));
            end
        end
    end

    // Watchdog: too long with no request taken and no result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("id_allowlist_table_tb: FAIL");
            $finish;
        end
    end

    // Issue one request after a random gap; returns once it is taken
    task automatic send_request(input logic [2:0] func, input logic [31:0] uid);
        ial_pkg::req_t item;
        ial_pkg::req_t noise;
        item.func = func;
        item.uid  = uid;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            noise.func = 3'($urandom);
            noise.uid  = $urandom;
            start   <= 1'b0;
            request <= noise;
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_list_op(item);
    endtask

    // Hold the sender off until every queued result has come back
    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
    endtask

    // Query, clear, delete and check on an empty list, plus an unknown code
    task automatic test_empty_list();
        send_request(ial_pkg::OP_QUERY, NO_CARD);
        send_request(ial_pkg::OP_CLEAR, NO_CARD);
        send_request(ial_pkg::OP_DEL, 32'd5);
        send_request(ial_pkg::OP_CHECK, NO_CARD);
        send_request(OP_FIRST_UNKNOWN, ALL_ONES_CARD);
        wait_for_results();
    endtask

    // Fill to capacity: zero card, duplicate and full-list refusals
    task automatic test_fill_and_refuse();
        send_request(ial_pkg::OP_ADD, NO_CARD);
        send_request(ial_pkg::OP_ADD, ALL_ONES_CARD);
        send_request(ial_pkg::OP_ADD, 32'd1);
        send_request(ial_pkg::OP_ADD, TOP_BIT_CARD);
        send_request(ial_pkg::OP_ADD, ALL_ONES_CARD);
        send_request(ial_pkg::OP_ADD, 32'h5555_AAAA);
        send_request(ial_pkg::OP_ADD, 32'h1234_5678);
        send_request(ial_pkg::OP_ADD, 32'd9);
        send_request(ial_pkg::OP_QUERY, NO_CARD);
        wait_for_results();
    endtask

    // Deletes at middle, tail and head; lookups; an unknown code; clear
    task automatic test_delete_and_compact();
        send_request(ial_pkg::OP_DEL, NO_CARD);
        send_request(ial_pkg::OP_DEL, 32'd3);
        send_request(ial_pkg::OP_DEL, 32'd1);
        send_request(ial_pkg::OP_DEL, 32'h1234_5678);
        send_request(ial_pkg::OP_DEL, ALL_ONES_CARD);
        send_request(ial_pkg::OP_CHECK, TOP_BIT_CARD);
        send_request(ial_pkg::OP_CHECK, ALL_ONES_CARD);
        send_request(OP_LAST_UNKNOWN, 32'd1);
        send_request(ial_pkg::OP_QUERY, NO_CARD);
        send_request(ial_pkg::OP_CLEAR, 32'hA5A5_5A5A);
        send_request(ial_pkg::OP_QUERY, NO_CARD);
        wait_for_results();
    endtask

    // Random traffic; cards mostly from a small pool so adds and deletes collide
    task automatic test_random_traffic(input int idle_pct, input int num_requests);
        logic [2:0]  func;
        logic [31:0] uid;
        int          pick;
        sender_idle_pct = idle_pct;
        for (int i = 0; i < POOL_SIZE; i++)
            uid_pool[i] = ($urandom_range(3) == 0) ? ALL_ONES_CARD - 32'(i) : $urandom | 32'd1;
        repeat (num_requests)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                func = ial_pkg::OP_ADD;
            else if (pick < 55)
                func = ial_pkg::OP_DEL;
            else if (pick < 70)
                func = ial_pkg::OP_CHECK;
            else if (pick < 74)
                func = ial_pkg::OP_CLEAR;
            else if (pick < 93)
                func = ial_pkg::OP_QUERY;
            else
                func = 3'($urandom_range(OP_FIRST_UNKNOWN, OP_LAST_UNKNOWN));
            pick = $urandom_range(99);
            if (pick < 70)
                uid = uid_pool[$urandom_range(POOL_SIZE - 1)];
            else if (pick < 78)
                uid = NO_CARD;
            else
                uid = $urandom;
            send_request(func, uid);
            if ($urandom_range(39) == 0)
                wait_for_results();
        end
        wait_for_results();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_fill_and_refuse();
        test_delete_and_compact();
        test_random_traffic(19, 120);
        test_random_traffic(45, 120);
        test_random_traffic(0, 120);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("id_allowlist_table_tb: PASS");
        else
            $display("id_allowlist_table_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/ial_pkg.sv
rtl/ial_dp.sv
rtl/ial_ctrl.sv
rtl/id_allowlist_table.sv
bench/id_allowlist_table_tb.sv
